[rtl/core/lz77_hash_chain_tokenizer_top_assert.svh]
// Assertion macros for the tokenizer top level.
`ifndef LZ77_HASH_CHAIN_TOKENIZER_TOP_ASSERT_SVH
`define LZ77_HASH_CHAIN_TOKENIZER_TOP_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define LZHC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold at every clock edge outside reset.
`define LZHC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

[rtl/core/lz77hc_pkg.sv]
`timescale 1ns / 1ps
package lz77hc_pkg;
  localparam int WINDOW_SIZE    = 32768;
  localparam int LOOKAHEAD_ROOM = 32768;
  localparam int HASH_BITS      = 15;
  localparam int MAX_MATCH      = 258;
  localparam int MIN_MATCH      = 3;
  localparam int POS_BITS       = 32;

  localparam int WIN_BITS   = $clog2(WINDOW_SIZE);
  localparam int RING_SIZE  = WINDOW_SIZE + LOOKAHEAD_ROOM;
  localparam int RING_BITS  = $clog2(RING_SIZE);
  localparam int NEED_AHEAD = MAX_MATCH + MIN_MATCH - 1;
  localparam int LEN_BITS   = 9;
  localparam int DIST_BITS  = 16;
  localparam int LIMIT_BITS = 13;
  localparam int CMD_BITS   = 2;
  localparam int STAT_BITS  = 3;

  localparam logic [LIMIT_BITS-1:0] CHAIN_LIMIT_RST = 13'd128;
  localparam logic [31:0]           HASH_MULT       = 32'd2654435761;

  typedef logic [POS_BITS-1:0] pos_t;

  typedef struct packed {
    logic ok;
    pos_t at;
  } ptr_t;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_APPEND  = 2'd0,
    CMD_END     = 2'd1,
    CMD_REQUEST = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [STAT_BITS-1:0] {
    ST_ACCEPTED  = 3'd0,
    ST_TOKEN     = 3'd1,
    ST_NEED_MORE = 3'd2,
    ST_DONE      = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HRD0,
    S_HRD1,
    S_HMUL,
    S_HEAD,
    S_HGOT,
    S_WCHK,
    S_CRD,
    S_CCMP,
    S_EVAL,
    S_LRD,
    S_LINK,
    S_NEXT,
    S_DONE
  } state_t;
endpackage

[rtl/core/lz77_hash_chain_tokenizer_top.sv]
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Beat contents
// in_      input      in_valid / in_ready    in_command, in_byte_value
// out_     output     out_valid / out_ready  out_status, out_is_match, out_match_length,
//                                            out_match_distance, out_literal
// cfg_     input      cfg_wr_en              cfg_wr_data (chain_limit)
// After reset and after every restart beat, a pass over all 32768 bucket heads empties them;
// no input beat is taken meanwhile. Append, end and restart beats, and requests that give no
// token, load the result register as they are taken. A token walks the bucket chain one candidate
// at a time, comparing one byte per step, then links each position inside a match; with fewer
// than three bytes left no hash is formed. The bucket and link memories have registered reads.
// Input is taken only when idle and the result register is free or being drained.
module lz77_hash_chain_tokenizer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lz77hc_pkg::CMD_BITS-1:0]     in_command,
  input  logic [7:0]                          in_byte_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lz77hc_pkg::STAT_BITS-1:0]    out_status,
  output logic                                out_is_match,
  output logic [lz77hc_pkg::LEN_BITS-1:0]     out_match_length,
  output logic [lz77hc_pkg::DIST_BITS-1:0]    out_match_distance,
  output logic [7:0]                          out_literal,
  input  logic                                cfg_wr_en,
  input  logic [lz77hc_pkg::LIMIT_BITS-1:0]   cfg_wr_data
);
  import lz77hc_pkg::*;

  // memories
  logic [7:0] ring_mem [RING_SIZE];
  ptr_t       head_mem [1 << HASH_BITS];
  ptr_t       link_mem [WINDOW_SIZE];

  state_t state_r, state_nxt;

  logic [LIMIT_BITS-1:0] chain_limit_r;
  logic [HASH_BITS-1:0]  clr_cnt_r;
  pos_t                  tp_r, br_r;
  logic                  ended_r;
  logic                  out_valid_r;
  logic [STAT_BITS-1:0]  out_status_r;
  logic                  out_is_match_r;
  logic [LEN_BITS-1:0]   out_len_r;
  logic [DIST_BITS-1:0]  out_dist_r;
  logic [7:0]            out_lit_r;

  // token datapath
  pos_t                  pos_r, pa_r, oldest_r, avail_r, cand_r;
  logic                  link_mode_r, hashable_r, cand_ok_r;
  logic [LEN_BITS-1:0]   mlimit_r, best_r, n_r, i_r;
  logic [DIST_BITS-1:0]  dist_r;
  logic [7:0]            b0_r, b1_r, lit_r, rd_a_r, rd_b_r;
  logic [HASH_BITS-1:0]  hash_r;
  logic [LIMIT_BITS-1:0] k_r;
  ptr_t                  head_r, head_rd_r, link_rd_r;

  // combinational
  cmd_t                  cmd;
  logic                  acc, slot_free, out_load, token_go, full, req_more, req_done;
  logic                  ring_we, head_we, link_we, best_match;
  logic [RING_BITS-1:0]  ring_ra_a, ring_ra_b;
  logic [HASH_BITS-1:0]  head_wa;
  ptr_t                  head_wd;
  pos_t                  avail, oldest;
  logic [31:0]           mult_prod;
  status_t               idle_status;

  assign cmd        = cmd_t'(in_command);
  assign acc        = in_valid && in_ready;
  assign slot_free  = !out_valid_r || out_ready;
  assign avail      = br_r - tp_r;
  assign oldest     = (tp_r > pos_t'(WINDOW_SIZE)) ? tp_r - pos_t'(WINDOW_SIZE) : '0;
  assign full       = ((br_r - oldest) >= pos_t'(RING_SIZE)) || (br_r == '1);
  assign req_done   = (tp_r >= br_r) && ended_r;
  assign req_more   = !ended_r && (avail < pos_t'(NEED_AHEAD));
  assign token_go   = (cmd == CMD_REQUEST) && !req_done && !req_more;
  assign best_match = best_r >= LEN_BITS'(MIN_MATCH);
  assign mult_prod  = {8'd0, b0_r, b1_r, rd_a_r} * HASH_MULT;

  always_comb begin
    unique case (cmd)
      CMD_APPEND: begin
        if (ended_r)   idle_status = ST_DONE;
        else if (full) idle_status = ST_FULL;
        else           idle_status = ST_ACCEPTED;
      end
      CMD_REQUEST: begin
        if (req_done)  idle_status = ST_DONE;
        else           idle_status = ST_NEED_MORE;
      end
      default:         idle_status = ST_ACCEPTED;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_cnt_r == '1) state_nxt = S_IDLE;
      S_IDLE: begin
        if (acc && cmd == CMD_RESTART) state_nxt = S_CLEAR;
        else if (acc && token_go)      state_nxt = S_HRD0;
      end
      S_HRD0: state_nxt = S_HRD1;
      S_HRD1: state_nxt = (!link_mode_r && !hashable_r) ? S_DONE : S_HMUL;
      S_HMUL: state_nxt = S_HEAD;
      S_HEAD: state_nxt = S_HGOT;
      S_HGOT: state_nxt = link_mode_r ? S_LINK : S_WCHK;
      S_WCHK: begin
        if (k_r < chain_limit_r && cand_ok_r && cand_r >= oldest_r && cand_r < pos_r)
          state_nxt = S_CRD;
        else
          state_nxt = S_LINK;
      end
      S_CRD:  state_nxt = (n_r < mlimit_r) ? S_CCMP : S_EVAL;
      S_CCMP: state_nxt = (rd_a_r == rd_b_r) ? S_CRD : S_EVAL;
      S_EVAL: state_nxt = (n_r > best_r && n_r == mlimit_r) ? S_LINK : S_LRD;
      S_LRD:  state_nxt = S_WCHK;
      S_LINK: state_nxt = S_NEXT;
      S_NEXT: begin
        if (best_match && i_r < best_r) begin
          if (pos_t'(i_r) + pos_t'(MIN_MATCH) <= avail_r) state_nxt = S_HRD0;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    pos_t sum_a, sum_b;
    sum_a     = pa_r;
    sum_b     = pa_r + pos_t'(1);
    in_ready  = (state_r == S_IDLE) && slot_free;
    out_load  = (acc && !token_go) || (state_r == S_DONE && slot_free);
    ring_we   = acc && cmd == CMD_APPEND && !ended_r && !full;
    head_we   = (state_r == S_CLEAR) || (state_r == S_LINK);
    link_we   = (state_r == S_LINK);
    head_wa   = (state_r == S_CLEAR) ? clr_cnt_r : hash_r;
    head_wd   = (state_r == S_CLEAR) ? '0 : ptr_t'{ok: 1'b1, at: pa_r};
    unique case (state_r)
      S_HRD1: sum_a = pa_r + pos_t'(2);
      S_CRD: begin
        sum_a = cand_r + pos_t'(n_r);
        sum_b = pos_r + pos_t'(n_r);
      end
      default: ;
    endcase
    ring_ra_a = sum_a[RING_BITS-1:0];
    ring_ra_b = sum_b[RING_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[br_r[RING_BITS-1:0]] <= in_byte_value;
    rd_a_r <= ring_mem[ring_ra_a];
    rd_b_r <= ring_mem[ring_ra_b];
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_r <= head_mem[hash_r];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[pa_r[WIN_BITS-1:0]] <= head_r;
    link_rd_r <= link_mem[cand_r[WIN_BITS-1:0]];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
      tp_r          <= '0;
      br_r          <= '0;
      ended_r       <= 1'b0;
      chain_limit_r <= CHAIN_LIMIT_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) chain_limit_r <= cfg_wr_data;
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (state_r == S_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (ring_we) br_r <= br_r + pos_t'(1);
      if (acc && cmd == CMD_END) ended_r <= 1'b1;
      if (acc && cmd == CMD_RESTART) begin
        tp_r      <= '0;
        br_r      <= '0;
        ended_r   <= 1'b0;
        clr_cnt_r <= '0;
      end
      if (state_r == S_DONE && slot_free)
        tp_r <= pos_r + (best_match ? pos_t'(best_r) : pos_t'(1));
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state_r == S_DONE) begin
        out_status_r   <= ST_TOKEN;
        out_is_match_r <= best_match;
        out_len_r      <= best_match ? best_r : '0;
        out_dist_r     <= best_match ? dist_r : '0;
        out_lit_r      <= best_match ? 8'd0 : lit_r;
      end else begin
        out_status_r   <= idle_status;
        out_is_match_r <= 1'b0;
        out_len_r      <= '0;
        out_dist_r     <= '0;
        out_lit_r      <= 8'd0;
      end
    end
  end

  // token datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (acc && token_go) begin
          pos_r       <= tp_r;
          pa_r        <= tp_r;
          link_mode_r <= 1'b0;
          oldest_r    <= oldest;
          avail_r     <= avail;
          mlimit_r    <= (avail >= pos_t'(MAX_MATCH)) ? LEN_BITS'(MAX_MATCH)
                                                     : avail[LEN_BITS-1:0];
          hashable_r  <= avail >= pos_t'(MIN_MATCH);
          best_r      <= '0;
          dist_r      <= '0;
          i_r         <= LEN_BITS'(1);
        end
      end
      S_HRD1: begin
        b0_r <= rd_a_r;
        b1_r <= rd_b_r;
        if (!link_mode_r) lit_r <= rd_a_r;
      end
      S_HMUL: hash_r <= mult_prod[31 -: HASH_BITS];
      S_HGOT: begin
        head_r <= head_rd_r;
        if (!link_mode_r) begin
          cand_r    <= head_rd_r.at;
          cand_ok_r <= head_rd_r.ok;
          k_r       <= '0;
        end
      end
      S_WCHK: n_r <= '0;
      S_CCMP: if (rd_a_r == rd_b_r) n_r <= n_r + 1'b1;
      S_EVAL: begin
        if (n_r > best_r) begin
          best_r <= n_r;
          dist_r <= DIST_BITS'(pos_r - cand_r);
        end
      end
      S_LRD: begin
        cand_r    <= link_rd_r.at;
        cand_ok_r <= link_rd_r.ok;
        k_r       <= k_r + 1'b1;
      end
      S_NEXT: begin
        if (best_match && i_r < best_r) begin
          i_r <= i_r + 1'b1;
          if (pos_t'(i_r) + pos_t'(MIN_MATCH) <= avail_r) begin
            pa_r        <= pos_r + pos_t'(i_r);
            link_mode_r <= 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_is_match       = out_is_match_r;
  assign out_match_length   = out_len_r;
  assign out_match_distance = out_dist_r;
  assign out_literal        = out_lit_r;

`include "lz77_hash_chain_tokenizer_top_assert.svh"

  `LZHC_ASSERT_ALWAYS(a_tp_le_br, tp_r <= br_r, "token position passed received bytes")
  `LZHC_ASSERT_IMP(a_match_shape, out_valid_r && out_is_match_r,
    out_len_r >= LEN_BITS'(MIN_MATCH) && out_dist_r != '0, "bad match token")
  `LZHC_ASSERT_IMP(a_cmp_bound, state_r == S_CRD, n_r <= mlimit_r,
    "compare ran past match limit")

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
module tb;
  import lz77hc_pkg::*;

  localparam longint unsigned POS_LIMIT   = (64'd1 << POS_BITS) - 1;
  localparam int              CYCLE_LIMIT = 8000000;
  localparam int              RAND_BEATS  = 1150;
  localparam int              SETTLE      = 60;

  typedef struct {
    status_t     st;
    logic        is_match;
    logic [8:0]  len;
    logic [15:0] distance;
    logic [7:0]  lit;
  } token_t;

  typedef struct {
    cmd_t       cmd;
    logic [7:0] val;
    bit         typed;
    token_t     want;
  } step_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [CMD_BITS-1:0]   in_command;
  logic [7:0]            in_byte_value;
  logic                  out_valid;
  logic                  out_ready;
  logic [STAT_BITS-1:0]  out_status;
  logic                  out_is_match;
  logic [LEN_BITS-1:0]   out_match_length;
  logic [DIST_BITS-1:0]  out_match_distance;
  logic [7:0]            out_literal;
  logic                  cfg_wr_en;
  logic [LIMIT_BITS-1:0] cfg_wr_data;

  lz77_hash_chain_tokenizer_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_byte_value     (in_byte_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_is_match      (out_is_match),
    .out_match_length  (out_match_length),
    .out_match_distance(out_match_distance),
    .out_literal       (out_literal),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always #10 clk = ~clk;

  // tokenizer mirror
  logic [7:0]      text_mem [RING_SIZE];
  bit              head_ok  [1 << HASH_BITS];
  longint unsigned head_pos [1 << HASH_BITS];
  bit              link_ok  [WINDOW_SIZE];
  longint unsigned link_pos [WINDOW_SIZE];
  longint unsigned tok_pos;
  longint unsigned bytes_in;
  bit              ended;
  int unsigned     chain_max;

  token_t tokens_due[$];
  int     errors;
  int     beats;
  bit     quiet;
  int     cycles;
  int     out_stall;

  function automatic logic [7:0] text_at(longint unsigned p);
    return text_mem[p % RING_SIZE];
  endfunction

  function automatic int unsigned bucket_of(longint unsigned p);
    logic [31:0] key;
    logic [31:0] prod;
    key  = {8'd0, text_at(p), text_at(p + 1), text_at(p + 2)};
    prod = key * HASH_MULT;
    return prod >> (32 - HASH_BITS);
  endfunction

  function automatic void link_pos_in(longint unsigned p);
    int unsigned b;
    int unsigned slot;
    b    = bucket_of(p);
    slot = 32'(p % WINDOW_SIZE);
    link_pos[slot] = head_pos[b];
    link_ok[slot]  = head_ok[b];
    head_pos[b]    = p;
    head_ok[b]     = 1'b1;
  endfunction

  function automatic void wipe_stream();
    foreach (text_mem[i]) text_mem[i] = '0;
    foreach (head_ok[i]) begin
      head_ok[i]  = 1'b0;
      head_pos[i] = 0;
    end
    foreach (link_ok[i]) begin
      link_ok[i]  = 1'b0;
      link_pos[i] = 0;
    end
    tok_pos  = 0;
    bytes_in = 0;
    ended    = 1'b0;
  endfunction

  function automatic token_t tokenize(cmd_t c, logic [7:0] val);
    token_t          r;
    longint unsigned oldest, avail, lim, best, best_dist, cand, n;
    int unsigned     k;
    bit              ok;
    r = '{ST_ACCEPTED, 1'b0, '0, '0, '0};
    oldest = tok_pos > WINDOW_SIZE ? tok_pos - WINDOW_SIZE : 0;
    case (c)
      CMD_APPEND: begin
        if (ended) begin
          r.st = ST_DONE;
        end else if (bytes_in - oldest >= RING_SIZE || bytes_in >= POS_LIMIT) begin
          r.st = ST_FULL;
        end else begin
          text_mem[bytes_in % RING_SIZE] = val;
          bytes_in++;
        end
      end
      CMD_END: ended = 1'b1;
      CMD_RESTART: wipe_stream();
      default: begin
        avail = bytes_in - tok_pos;
        if (tok_pos >= bytes_in && ended) begin
          r.st = ST_DONE;
        end else if (!ended && avail < NEED_AHEAD) begin
          r.st = ST_NEED_MORE;
        end else begin
          r.st      = ST_TOKEN;
          best      = 0;
          best_dist = 0;
          lim       = avail < MAX_MATCH ? avail : MAX_MATCH;
          if (avail >= MIN_MATCH) begin
            ok   = head_ok[bucket_of(tok_pos)];
            cand = head_pos[bucket_of(tok_pos)];
            for (k = 0; k < chain_max && ok; k++) begin
              if (cand < oldest || cand >= tok_pos) break;
              n = 0;
              while (n < lim && text_at(cand + n) == text_at(tok_pos + n)) n++;
              if (n > best) begin
                best      = n;
                best_dist = tok_pos - cand;
                if (n == lim) break;
              end
              ok   = link_ok[cand % WINDOW_SIZE];
              cand = link_pos[cand % WINDOW_SIZE];
            end
            link_pos_in(tok_pos);
          end
          if (best >= MIN_MATCH) begin
            r.is_match = 1'b1;
            r.len      = 9'(best);
            r.distance = 16'(best_dist);
            for (longint unsigned i = 1; i < best; i++) begin
              if (i + MIN_MATCH <= avail) link_pos_in(tok_pos + i);
            end
            tok_pos += best;
          end else begin
            r.lit = text_at(tok_pos);
            tok_pos++;
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_beat(cmd_t c, logic [7:0] val, bit typed = 1'b0,
                           token_t want = '{ST_ACCEPTED, 1'b0, '0, '0, '0});
    token_t got;
    in_valid      <= 1'b1;
    in_command    <= c;
    in_byte_value <= val;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    got = tokenize(c, val);
    tokens_due.push_back(typed ? want : got);
    beats++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // hold input until every token is back and the core has gone quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(int unsigned v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= LIMIT_BITS'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    chain_max = v;
  endtask

  task automatic run_stream(int nbytes);
    logic [7:0] src[$];
    logic [7:0] b;
    int         sent, mode, span;
    sent = 0;
    send_beat(CMD_RESTART, 8'h00);
    while (sent < nbytes) begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(1, 40)) begin
        if (mode == 1) begin
          b = 8'(8'h41 + $urandom_range(0, 2));
        end else if (mode == 2 && src.size() > 10) begin
          span = src.size() - 1 > 300 ? 300 : src.size() - 1;
          b = src[src.size() - 1 - $urandom_range(0, span)];
        end else begin
          b = 8'($urandom_range(0, 255));
        end
        src.push_back(b);
        send_beat(CMD_APPEND, b);
        sent++;
      end
      while (bytes_in - tok_pos >= NEED_AHEAD && $urandom_range(0, 4) != 0)
        send_beat(CMD_REQUEST, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 15) == 0) send_beat(CMD_REQUEST, 8'($urandom_range(0, 255)));
    end
    send_beat(CMD_END, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1)) send_beat(CMD_END, 8'($urandom_range(0, 255)));
    send_beat(CMD_APPEND, 8'($urandom_range(0, 255)));
    while (tok_pos < bytes_in) send_beat(CMD_REQUEST, 8'($urandom_range(0, 255)));
    send_beat(CMD_REQUEST, 8'($urandom_range(0, 255)));
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!quiet && out_stall == 0 && $urandom_range(0, 4) == 0)
      out_stall = $urandom_range(1, 3);
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(negedge clk) begin
    token_t w;
    if (rst_n && out_valid && out_ready) begin
      if (tokens_due.size() == 0) begin
        $display("%0t unexpected beat status=%0d", $time, out_status);
        errors++;
      end else begin
        w = tokens_due.pop_front();
        if (out_status !== w.st) begin
          $display("%0t status exp %0d got %0d", $time, w.st, out_status);
          errors++;
        end
        if (out_is_match !== w.is_match) begin
          $display("%0t is_match exp %0d got %0d", $time, w.is_match, out_is_match);
          errors++;
        end
        if (out_match_length !== w.len) begin
          $display("%0t length exp %0d got %0d", $time, w.len, out_match_length);
          errors++;
        end
        if (out_match_distance !== w.distance) begin
          $display("%0t distance exp %0d got %0d", $time, w.distance, out_match_distance);
          errors++;
        end
        if (out_literal !== w.lit) begin
          $display("%0t literal exp %0h got %0h", $time, w.lit, out_literal);
          errors++;
        end
      end
    end
  end

  initial begin
    step_row_t   steps[$];
    int unsigned limits[6];
    int          i;
    int          nb;
    token_t      acc, need, done;
    acc  = '{ST_ACCEPTED, 1'b0, '0, '0, '0};
    need = '{ST_NEED_MORE, 1'b0, '0, '0, '0};
    done = '{ST_DONE, 1'b0, '0, '0, '0};
    errors = 0; beats = 0; quiet = 1'b0; cycles = 0; out_stall = 0;
    rst_n <= 1'b0; in_valid <= 1'b0; in_command <= CMD_APPEND; in_byte_value <= '0;
    out_ready <= 1'b0; cfg_wr_en <= 1'b0; cfg_wr_data <= '0;
    wipe_stream();
    chain_max = CHAIN_LIMIT_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    steps.push_back('{CMD_REQUEST, 8'h00, 1, need});
    for (i = 0; i < 8; i++) steps.push_back('{CMD_APPEND, i[0] ? 8'hFF : 8'h00, 1, acc});
    steps.push_back('{CMD_REQUEST, 8'hFF, 1, need});
    steps.push_back('{CMD_END, 8'h00, 1, acc});
    steps.push_back('{CMD_END, 8'hFF, 1, acc});
    steps.push_back('{CMD_APPEND, 8'h5A, 1, done});
    steps.push_back('{CMD_REQUEST, 8'h00, 1, '{ST_TOKEN, 1'b0, '0, '0, 8'h00}});
    steps.push_back('{CMD_REQUEST, 8'h00, 1, '{ST_TOKEN, 1'b0, '0, '0, 8'hFF}});
    steps.push_back('{CMD_REQUEST, 8'h00, 0, acc});
    steps.push_back('{CMD_REQUEST, 8'h00, 1, done});
    steps.push_back('{CMD_RESTART, 8'hA5, 1, acc});
    steps.push_back('{CMD_APPEND, 8'h7E, 1, acc});
    steps.push_back('{CMD_END, 8'h00, 1, acc});
    steps.push_back('{CMD_REQUEST, 8'h00, 1, '{ST_TOKEN, 1'b0, '0, '0, 8'h7E}});
    steps.push_back('{CMD_REQUEST, 8'h00, 1, done});
    foreach (steps[j]) send_beat(steps[j].cmd, steps[j].val, steps[j].typed, steps[j].want);

    limits = '{13'h1FFF, 0, 2, 4096, 1, 128};
    i = 0;
    while (beats < RAND_BEATS) begin
      write_limit(i < 6 ? limits[i] : $urandom_range(1, 4096));
      if (beats > RAND_BEATS - 300) quiet = 1'b1;
      // keep the last stream short so the total stays near the target
      nb = $urandom_range(150, 400);
      if (nb > (RAND_BEATS - beats) / 2 + 20) nb = (RAND_BEATS - beats) / 2 + 20;
      run_stream(nb);
      i++;
    end

    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
